/* rtl/core/osi_pkg.sv */
// Package for the ordered set intersection block: command codes, the
// sequencer's control word and flag types, and the microprogram table.
// No dependencies; used by osi_seq and ordered_set_intersection.
package osi_pkg;

   localparam int VALUE_W           = 32;
   localparam int CMD_W             = 2;
   localparam int LIST_CAPACITY_DEF = 32;
   localparam int PC_W              = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_FIRST  = 2'd0,
      CMD_ADD_SECOND = 2'd1,
      CMD_FINISH     = 2'd2
   } osi_cmd_type;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_ACCEPT,
      ACT_SCAN,
      ACT_WRITE,
      ACT_DROP,
      ACT_OUTER_CLR,
      ACT_READ_A,
      ACT_LOAD_KEY,
      ACT_PUSH,
      ACT_OUTER_INC,
      ACT_FINAL,
      ACT_CLEAR
   } osi_action_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CMD_FIN,
      COND_CMD_BAD,
      COND_SCAN_MORE,
      COND_HIT,
      COND_NOT_HIT,
      COND_FULL,
      COND_OUTER_DONE,
      COND_PUSH_BLOCK,
      COND_OUT_BLOCK
   } osi_cond_type;

   typedef struct packed {
      osi_action_type   action;
      osi_cond_type     cond;
      logic [PC_W-1:0]  target;
   } osi_ctrl_type;

   typedef struct packed {
      logic no_req;
      logic cmd_fin;
      logic cmd_bad;
      logic scan_more;
      logic hit;
      logic full;
      logic outer_done;
      logic push_block;
      logic out_block;
   } osi_flags_type;

   // step addresses
   localparam logic [PC_W-1:0] STEP_IDLE   = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_DISP   = PC_W'(1);
   localparam logic [PC_W-1:0] STEP_CHKBAD = PC_W'(2);
   localparam logic [PC_W-1:0] STEP_LSCAN  = PC_W'(3);
   localparam logic [PC_W-1:0] STEP_LDRAIN = PC_W'(4);
   localparam logic [PC_W-1:0] STEP_LHIT   = PC_W'(5);
   localparam logic [PC_W-1:0] STEP_LFULL  = PC_W'(6);
   localparam logic [PC_W-1:0] STEP_LWRITE = PC_W'(7);
   localparam logic [PC_W-1:0] STEP_LDROP  = PC_W'(8);
   localparam logic [PC_W-1:0] STEP_FSTART = PC_W'(9);
   localparam logic [PC_W-1:0] STEP_FOUTER = PC_W'(10);
   localparam logic [PC_W-1:0] STEP_FKEY   = PC_W'(11);
   localparam logic [PC_W-1:0] STEP_FSCAN  = PC_W'(12);
   localparam logic [PC_W-1:0] STEP_FDRAIN = PC_W'(13);
   localparam logic [PC_W-1:0] STEP_FHIT   = PC_W'(14);
   localparam logic [PC_W-1:0] STEP_FPUSH  = PC_W'(15);
   localparam logic [PC_W-1:0] STEP_FNEXT  = PC_W'(16);
   localparam logic [PC_W-1:0] STEP_FEND   = PC_W'(17);
   localparam logic [PC_W-1:0] STEP_FCLR   = PC_W'(18);

   // Microprogram: jump to target when cond holds, else advance by one.
   function automatic osi_ctrl_type ucode(input logic [PC_W-1:0] pc);
      osi_ctrl_type w;
      case (pc)
         STEP_IDLE:   w = '{ACT_ACCEPT,    COND_NO_REQ,     STEP_IDLE};
         STEP_DISP:   w = '{ACT_NOP,       COND_CMD_FIN,    STEP_FSTART};
         STEP_CHKBAD: w = '{ACT_NOP,       COND_CMD_BAD,    STEP_IDLE};
         STEP_LSCAN:  w = '{ACT_SCAN,      COND_SCAN_MORE,  STEP_LSCAN};
         STEP_LDRAIN: w = '{ACT_NOP,       COND_NEVER,      STEP_IDLE};
         STEP_LHIT:   w = '{ACT_NOP,       COND_HIT,        STEP_IDLE};
         STEP_LFULL:  w = '{ACT_NOP,       COND_FULL,       STEP_LDROP};
         STEP_LWRITE: w = '{ACT_WRITE,     COND_ALWAYS,     STEP_IDLE};
         STEP_LDROP:  w = '{ACT_DROP,      COND_ALWAYS,     STEP_IDLE};
         STEP_FSTART: w = '{ACT_OUTER_CLR, COND_NEVER,      STEP_IDLE};
         STEP_FOUTER: w = '{ACT_READ_A,    COND_OUTER_DONE, STEP_FEND};
         STEP_FKEY:   w = '{ACT_LOAD_KEY,  COND_NEVER,      STEP_IDLE};
         STEP_FSCAN:  w = '{ACT_SCAN,      COND_SCAN_MORE,  STEP_FSCAN};
         STEP_FDRAIN: w = '{ACT_NOP,       COND_NEVER,      STEP_IDLE};
         STEP_FHIT:   w = '{ACT_NOP,       COND_NOT_HIT,    STEP_FNEXT};
         STEP_FPUSH:  w = '{ACT_PUSH,      COND_PUSH_BLOCK, STEP_FPUSH};
         STEP_FNEXT:  w = '{ACT_OUTER_INC, COND_ALWAYS,     STEP_FOUTER};
         STEP_FEND:   w = '{ACT_FINAL,     COND_OUT_BLOCK,  STEP_FEND};
         STEP_FCLR:   w = '{ACT_CLEAR,     COND_ALWAYS,     STEP_IDLE};
         default:     w = '{ACT_NOP,       COND_ALWAYS,     STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/osi_seq.sv */
// Microcode sequencer for the ordered set intersection block: step counter,
// program table lookup and conditional jump. Depends on osi_pkg.
module osi_seq
   import osi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  osi_flags_type flags,
   output osi_ctrl_type  ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_NO_REQ:     take = flags.no_req;
         COND_CMD_FIN:    take = flags.cmd_fin;
         COND_CMD_BAD:    take = flags.cmd_bad;
         COND_SCAN_MORE:  take = flags.scan_more;
         COND_HIT:        take = flags.hit;
         COND_NOT_HIT:    take = !flags.hit;
         COND_FULL:       take = flags.full;
         COND_OUTER_DONE: take = flags.outer_done;
         COND_PUSH_BLOCK: take = flags.push_block;
         COND_OUT_BLOCK:  take = flags.out_block;
         default:         take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : pc_ff + PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* rtl/core/ordered_set_intersection.sv */
// Ordered set intersection: two deduplicating lists, finish emits the common
// values in first-list order. A load of a new value first searches the target
// list for a duplicate, the search reading its list memory one entry per
// cycle, and skips the write when the value is already held; an unused
// command code is dropped. A finish scans the whole second-list memory for
// each first-list entry and waits while the result register is stalled.
// Items are taken one at a time; a finished result waits in the output
// register without holding off the next item. Depends on osi_pkg and osi_seq.
module ordered_set_intersection
   import osi_pkg::*;
#(
   parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_match_value,
   output logic                      rsp_last,
   output logic                      rsp_empty_res,
   output logic                      rsp_overflow
);

   localparam int AW = $clog2(LIST_CAPACITY);
   localparam int CW = $clog2(LIST_CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(LIST_CAPACITY);

   osi_ctrl_type   ctrl;
   osi_flags_type  flags;
   osi_action_type act;

   logic [VALUE_W-1:0] first_mem  [LIST_CAPACITY];
   logic [VALUE_W-1:0] second_mem [LIST_CAPACITY];

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               tsel_ff, tsel_in;
   logic [CW-1:0]      cnt_a_ff, cnt_a_in;
   logic [CW-1:0]      cnt_b_ff, cnt_b_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic               hit_ff, hit_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic               drop_ff, drop_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [VALUE_W-1:0] pend_ff, pend_in;
   logic [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0]      len_sel;
   logic [VALUE_W-1:0] rd_sel;
   logic               scan_go;
   logic               out_block;
   logic               rsp_load;
   logic               wr_a, wr_b;
   logic [AW-1:0]      addr_a, addr_b, wr_addr;

   osi_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign act       = ctrl.action;
   assign req_stall = (act != ACT_ACCEPT);
   assign len_sel   = tsel_ff ? cnt_b_ff : cnt_a_ff;
   assign rd_sel    = tsel_ff ? rd_b_ff : rd_a_ff;
   assign scan_go   = (act == ACT_SCAN) && (j_ff < len_sel);
   assign out_block = rsp_valid_ff && rsp_stall;

   assign wr_a    = (act == ACT_WRITE) && !tsel_ff;
   assign wr_b    = (act == ACT_WRITE) && tsel_ff;
   assign wr_addr = len_sel[AW-1:0];
   assign addr_a  = (act == ACT_READ_A) ? i_ff[AW-1:0] : j_ff[AW-1:0];
   assign addr_b  = j_ff[AW-1:0];

   always_comb begin
      flags.no_req     = !req_valid;
      flags.cmd_fin    = (cmd_ff == CMD_FINISH);
      flags.cmd_bad    = !(cmd_ff inside {CMD_ADD_FIRST, CMD_ADD_SECOND});
      flags.scan_more  = ({1'b0, j_ff} + (CW + 1)'(1)) < {1'b0, len_sel};
      flags.hit        = hit_ff;
      flags.full       = (len_sel == CAP_CNT);
      flags.outer_done = (i_ff >= cnt_a_ff);
      flags.push_block = pend_valid_ff && out_block;
      flags.out_block  = out_block;
   end

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      tsel_in       = tsel_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      hit_in        = hit_ff;
      drop_in       = drop_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      cmp_valid_in  = scan_go;

      // compare the entry read in the previous scan cycle
      if (cmp_valid_ff && (rd_sel == key_ff)) begin
         hit_in = 1'b1;
      end

      case (act)
         ACT_ACCEPT: begin
            if (req_valid) begin
               cmd_in  = req_command;
               key_in  = req_value;
               tsel_in = (req_command == CMD_ADD_SECOND);
               j_in    = '0;
               hit_in  = 1'b0;
            end
         end
         ACT_SCAN: begin
            if (scan_go) begin
               j_in = j_ff + CW'(1);
            end
         end
         ACT_WRITE: begin
            if (tsel_ff) begin
               cnt_b_in = cnt_b_ff + CW'(1);
            end else begin
               cnt_a_in = cnt_a_ff + CW'(1);
            end
         end
         ACT_DROP: begin
            drop_in = 1'b1;
         end
         ACT_OUTER_CLR: begin
            i_in          = '0;
            pend_valid_in = 1'b0;
         end
         ACT_LOAD_KEY: begin
            key_in  = rd_a_ff;
            j_in    = '0;
            hit_in  = 1'b0;
            tsel_in = 1'b1;
         end
         ACT_PUSH: begin
            // emit the held match, then hold the new one until we know
            // whether another follows; an empty holding slot never waits
            if (!(pend_valid_ff && out_block)) begin
               if (pend_valid_ff) begin
                  rsp_load     = 1'b1;
                  rsp_value_in = pend_ff;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = 1'b0;
                  rsp_ovf_in   = drop_ff;
               end
               pend_in       = key_ff;
               pend_valid_in = 1'b1;
            end
         end
         ACT_OUTER_INC: begin
            i_in = i_ff + CW'(1);
         end
         ACT_FINAL: begin
            if (!out_block) begin
               rsp_load     = 1'b1;
               rsp_value_in = pend_valid_ff ? pend_ff : '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = !pend_valid_ff;
               rsp_ovf_in   = drop_ff;
            end
         end
         ACT_CLEAR: begin
            cnt_a_in      = '0;
            cnt_b_in      = '0;
            drop_in       = 1'b0;
            pend_valid_in = 1'b0;
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         first_mem[wr_addr] <= key_ff;
      end
      rd_a_ff <= first_mem[addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         second_mem[wr_addr] <= key_ff;
      end
      rd_b_ff <= second_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         hit_ff        <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         drop_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         hit_ff        <= hit_in;
         cmp_valid_ff  <= cmp_valid_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      tsel_ff      <= tsel_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      pend_ff      <= pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_overflow    = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CAP_CNT) && (cnt_b_ff <= CAP_CNT))
      else $error("list count beyond capacity");

   a_drop_needs_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> ((cnt_a_ff == CAP_CNT) || (cnt_b_ff == CAP_CNT)))
      else $error("overflow flagged while no list is full");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && (rsp_value_ff == '0)))
      else $error("empty result not marked last or carries a value");
`endif

endmodule
